### hw/rtl/ehtd_pkg.sv
// Package for the English Huffman text decoder: state encoding, stored state word,
// the constant code tree and related constants. No dependencies.
`timescale 1ns / 1ps

package ehtd_pkg;

    localparam int unsigned MAX_MESSAGE_LEN = 127;
    localparam int unsigned NODE_COUNT      = 26;
    localparam int unsigned NODE_W          = 5;
    localparam int unsigned POS_W           = 6;
    localparam int unsigned CNT_W           = 7;
    localparam int unsigned SYM_W           = 7;
    localparam int unsigned COUNT_SAT       = 127;

    // Depth of the stored decoder state (a single entry)
    localparam int unsigned STATE_DEPTH = 1;
    localparam int unsigned STATE_AW    = 1;

    localparam logic [7:0] LEAF = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WALK,
        S_FLUSH,
        S_STORE
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
    } state_word_t;

    // Child of an internal node for one code bit: internal node number,
    // or LEAF plus the leaf character.
    function automatic logic [7:0] tree_child(input logic [NODE_W-1:0] node,
                                              input logic bit_val);
        logic [7:0] c0;
        logic [7:0] c1;
        begin
            unique case (node)
                5'd0:    begin c0 = 8'd20;          c1 = 8'd1;          end
                5'd1:    begin c0 = 8'd14;          c1 = 8'd2;          end
                5'd2:    begin c0 = 8'd12;          c1 = 8'd3;          end
                5'd3:    begin c0 = LEAF | 8'("t"); c1 = 8'd4;          end
                5'd4:    begin c0 = 8'd6;           c1 = 8'd5;          end
                5'd5:    begin c0 = LEAF | 8'("w"); c1 = LEAF | 8'("m"); end
                5'd6:    begin c0 = 8'd7;           c1 = LEAF | 8'("f"); end
                5'd7:    begin c0 = LEAF | 8'("v"); c1 = 8'd8;          end
                5'd8:    begin c0 = 8'd9;           c1 = LEAF | 8'("k"); end
                5'd9:    begin c0 = 8'd11;          c1 = 8'd10;         end
                5'd10:   begin c0 = LEAF | 8'("x"); c1 = LEAF | 8'("j"); end
                5'd11:   begin c0 = LEAF | 8'("z"); c1 = LEAF | 8'("q"); end
                5'd12:   begin c0 = LEAF | 8'("a"); c1 = 8'd13;         end
                5'd13:   begin c0 = LEAF | 8'("l"); c1 = LEAF | 8'("d"); end
                5'd14:   begin c0 = 8'd19;          c1 = 8'd15;         end
                5'd15:   begin c0 = 8'd16;          c1 = LEAF | 8'("o"); end
                5'd16:   begin c0 = 8'd18;          c1 = 8'd17;         end
                5'd17:   begin c0 = LEAF | 8'("y"); c1 = LEAF | 8'("g"); end
                5'd18:   begin c0 = LEAF | 8'("b"); c1 = LEAF | 8'("p"); end
                5'd19:   begin c0 = LEAF | 8'("n"); c1 = LEAF | 8'("i"); end
                5'd20:   begin c0 = 8'd22;          c1 = 8'd21;         end
                5'd21:   begin c0 = LEAF | 8'("e"); c1 = LEAF | 8'(" "); end
                5'd22:   begin c0 = 8'd24;          c1 = 8'd23;         end
                5'd23:   begin c0 = LEAF | 8'("h"); c1 = LEAF | 8'("s"); end
                5'd24:   begin c0 = 8'd25;          c1 = LEAF | 8'("r"); end
                5'd25:   begin c0 = LEAF | 8'("u"); c1 = LEAF | 8'("c"); end
                default: begin c0 = 8'd20;          c1 = 8'd1;          end
            endcase
            return bit_val ? c1 : c0;
        end
    endfunction

endpackage

### hw/rtl/ehtd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ehtd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/english_huffman_text_decoder.sv
// Sequence: the accepting cycle reads the stored state, then load, a walk of one code bit
// per cycle (held while a found character cannot leave, ended early at the limit), flush
// and store; the last character of a byte leaves at flush, earlier ones as soon as the
// next leaf is found. A new byte is taken only in idle (in_stall is high in every other
// state); a byte dropped at the limit goes from load straight to store.
// Reset: asynchronous, active low; stored entry marked empty (next load: root, count zero).
`timescale 1ns / 1ps

module english_huffman_text_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    code_byte,
    input  logic                          first_byte,
    input  logic [6:0]                    char_limit,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ehtd_pkg::SYM_W-1:0]    symbol,
    output logic                          last_of_item
);

    import ehtd_pkg::*;

    // Control state
    state_t            state_reg, state_next;
    logic [2:0]        bit_idx_reg, bit_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              word_valid_reg, word_valid_next;

    // Payload / working registers
    logic [7:0]        byte_reg, byte_next;
    logic              first_reg, first_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic [NODE_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SYM_W-1:0]  pend_sym_reg, pend_sym_next;
    logic [SYM_W-1:0]  out_sym_reg, out_sym_next;
    logic              out_last_reg, out_last_next;

    // State memory ports
    logic              ram_wr_en;
    logic              ram_rd_en;
    state_word_t       ram_wr_word;
    logic [$bits(state_word_t)-1:0] ram_rd_data;
    state_word_t       load_word;

    logic              in_take;
    logic              out_take;
    logic              can_push;
    logic [7:0]        child;
    logic [CNT_W-1:0]  cnt_inc;

    ehtd_ram #(
        .WIDTH ($bits(state_word_t)),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (STATE_AW'(0)),
        .wr_data (ram_wr_word),
        .rd_en   (ram_rd_en),
        .rd_addr (STATE_AW'(0)),
        .rd_data (ram_rd_data)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign in_take      = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign symbol       = out_sym_reg;
    assign last_of_item = out_last_reg;
    assign out_take     = out_valid_reg && !out_stall;
    // Output register can take a new character this cycle
    assign can_push     = !out_valid_reg || out_take;

    assign child   = tree_child(pos_reg, byte_reg[bit_idx_reg]);
    assign cnt_inc = (cnt_reg < CNT_W'(COUNT_SAT)) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        state_next      = state_reg;
        bit_idx_next    = bit_idx_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_take;
        word_valid_next = word_valid_reg;
        byte_next       = byte_reg;
        first_next      = first_reg;
        lim_next        = lim_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        pend_sym_next   = pend_sym_reg;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_wr_word.pos = POS_W'(pos_reg);
        ram_wr_word.cnt = cnt_reg;

        // An empty entry (never written since reset) or a restart reads as root, zero
        load_word = state_word_t'(ram_rd_data);
        if (!word_valid_reg || first_reg)
        begin
            load_word = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    byte_next  = code_byte;
                    first_next = first_byte;
                    // Clamp the limit to the longest message supported
                    if (8'(char_limit) > 8'(MAX_MESSAGE_LEN))
                    begin
                        lim_next = CNT_W'(MAX_MESSAGE_LEN);
                    end
                    else
                    begin
                        lim_next = char_limit;
                    end
                    ram_rd_en  = 1'b1;
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                // Treat an unused node number as the root
                if (load_word.pos >= POS_W'(NODE_COUNT))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = NODE_W'(load_word.pos);
                end
                cnt_next        = load_word.cnt;
                pend_valid_next = 1'b0;
                bit_idx_next    = 3'd7;
                // Limit already reached: drop the byte, keep the walk where it is
                if (load_word.cnt >= lim_reg)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (child[7])
                begin
                    // Hold while the previous character cannot leave yet
                    if (!pend_valid_reg || can_push)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_sym_next   = pend_sym_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = child[SYM_W-1:0];
                        pos_next        = '0;
                        cnt_next        = cnt_inc;
                        // Stop at the end of the byte or once the limit is hit
                        if (cnt_inc >= lim_reg || bit_idx_reg == 3'd0)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    pos_next = child[NODE_W-1:0];
                    if (bit_idx_reg == 3'd0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                    end
                end
            end

            S_FLUSH:
            begin
                // Release the held character as the last one of this byte
                if (pend_valid_reg)
                begin
                    if (can_push)
                    begin
                        out_valid_next  = 1'b1;
                        out_sym_next    = pend_sym_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_STORE;
                    end
                end
                else
                begin
                    state_next = S_STORE;
                end
            end

            S_STORE:
            begin
                ram_wr_en       = 1'b1;
                word_valid_next = 1'b1;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bit_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_idx_reg    <= bit_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        first_reg    <= first_next;
        lim_reg      <= lim_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        pend_sym_reg <= pend_sym_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

endmodule
